FILE: sv/battery_bar_led_indicator_core_macros.svh
// ----------------------------------------------------------------------------
// battery bar led indicator - assertion macros
// shared property wrappers, clocked on the rising edge, quiet during reset
// ----------------------------------------------------------------------------
`ifndef BATTERY_BAR_LED_INDICATOR_CORE_MACROS_SVH
`define BATTERY_BAR_LED_INDICATOR_CORE_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define BBLI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define BBLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/bbli_pkg.sv
// ----------------------------------------------------------------------------
// bbli_pkg
// codes, widths and reset values for the battery bar led indicator
// ----------------------------------------------------------------------------
`default_nettype none

package bbli_pkg;

   // field widths
   localparam int FIELD_ADC_W = 12;
   localparam int KIND_W      = 3;
   localparam int MODE_W      = 3;
   localparam int LEVEL_W     = 3;
   localparam int LAMP_W      = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int NUM_THR     = 4;

   localparam int ADC_BITS_DEF = 12;

   typedef logic [KIND_W-1:0]  kind_type;
   typedef logic [MODE_W-1:0]  mode_type;
   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [LAMP_W-1:0]  lamp_type;

   // item kinds
   localparam kind_type KIND_REFRESH   = 3'd0;
   localparam kind_type KIND_SET_VALUE = 3'd1;
   localparam kind_type KIND_CHG_MODE  = 3'd2;
   localparam kind_type KIND_CLR_STAT  = 3'd3;
   localparam kind_type KIND_INIT      = 3'd4;

   // display modes
   localparam mode_type MODE_OFF        = 3'd0;
   localparam mode_type MODE_BAT        = 3'd1;
   localparam mode_type MODE_BAT_INSTR  = 3'd2;
   localparam mode_type MODE_RATE_SET   = 3'd3;
   localparam mode_type MODE_RATE_INSTR = 3'd4;
   localparam mode_type MODE_CHARGING   = 3'd5;
   localparam mode_type MODE_GEAR_SET   = 3'd6;

   // bar levels
   localparam level_type LOW_BAR  = 3'd1;
   localparam level_type TOP_BAR  = 3'd5;
   localparam level_type FULL_BAR = 3'd6;
   localparam level_type NO_LEVEL = 3'd0;

   // threshold register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THR_1 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_2 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_3 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_4 = 2'd3;

   // threshold reset values
   localparam logic [CSR_DATA_W-1:0] THR_1_RST = 12'd2048;
   localparam logic [CSR_DATA_W-1:0] THR_2_RST = 12'd2560;
   localparam logic [CSR_DATA_W-1:0] THR_3_RST = 12'd3072;
   localparam logic [CSR_DATA_W-1:0] THR_4_RST = 12'd3584;

endpackage

`default_nettype wire

FILE: sv/battery_bar_led_indicator_core.sv
// ----------------------------------------------------------------------------
// battery_bar_led_indicator_core
// a transferred request is loaded into the input register and then processed
// into the state and response registers; one request per cycle unless the
// response stalls, set by the single state update pass
// a stalled response holds the input register, one further request waits there
// reset: synchronous, mode off, level 0, lamps off, thresholds to defaults
// ----------------------------------------------------------------------------
`default_nettype none

`include "battery_bar_led_indicator_core_macros.svh"

module battery_bar_led_indicator_core #(
   parameter int ADC_BITS = bbli_pkg::ADC_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // request channel
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [bbli_pkg::KIND_W-1:0]         req_kind,
   input  wire  [bbli_pkg::FIELD_ADC_W-1:0]    req_battery_level,
   input  wire                                 req_charge_nearly_full,
   input  wire                                 req_gear_update_due,
   input  wire                                 req_setting_exit_due,
   input  wire                                 req_instruction_exit_due,
   input  wire                                 req_arm_off,
   input  wire                                 req_enter_setting,
   input  wire  [bbli_pkg::MODE_W-1:0]         req_target_mode,
   input  wire  [bbli_pkg::LEVEL_W-1:0]        req_setting_value,
   // response channel
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [bbli_pkg::LAMP_W-1:0]         rsp_led_pattern,
   output logic [bbli_pkg::LEVEL_W-1:0]        rsp_shown_level,
   output logic [bbli_pkg::MODE_W-1:0]         rsp_display_mode,
   output logic [bbli_pkg::LEVEL_W-1:0]        rsp_rate_value,
   output logic [bbli_pkg::LEVEL_W-1:0]        rsp_initial_level,
   output logic [bbli_pkg::LEVEL_W-1:0]        rsp_blink_request,
   // register write channel
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [bbli_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [bbli_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import bbli_pkg::*;

   // compare width: low ADC_BITS bits of the 12-bit reading, at most all 12
   localparam int CMP_W = (ADC_BITS < FIELD_ADC_W) ? ADC_BITS : FIELD_ADC_W;

   typedef logic [CMP_W-1:0] adc_type;

   // thresholds
   adc_type   thr_ff [NUM_THR];

   // input register
   logic      in_valid_ff, in_valid_in;
   kind_type  kind_ff;
   adc_type   adc_ff;
   logic      nearly_full_ff, tick_ff, set_exit_ff, instr_exit_ff;
   logic      arm_ff, enter_ff;
   mode_type  target_ff;
   level_type value_ff;

   // block state
   mode_type  mode_ff, mode_in;
   level_type held_ff, held_in;
   lamp_type  lamp_ff, lamp_in;
   logic      setting_ff, setting_in;
   logic      off_armed_ff, off_armed_in;
   level_type rate_ff, rate_in;
   level_type init_ff, init_in;

   // response register
   logic      rsp_valid_ff, rsp_valid_in;
   level_type blink_ff, blink_in;

   logic      go;
   logic      req_take;

   // handshake
   assign go        = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !go;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take ? 1'b1 : (go ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = go ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   // bar level from a reading, strict greater-than thresholds
   function automatic level_type bar_of(input adc_type adc, input adc_type t1,
                                        input adc_type t2, input adc_type t3,
                                        input adc_type t4);
      level_type lv;
      begin
         if (adc > t4)      lv = TOP_BAR;
         else if (adc > t3) lv = 3'd4;
         else if (adc > t2) lv = 3'd3;
         else if (adc > t1) lv = 3'd2;
         else               lv = LOW_BAR;
         return lv;
      end
   endfunction

   // next state for the item in the input register
   always_comb begin
      level_type lv_bar;
      level_type lv;
      logic      leave_any;
      mode_in      = mode_ff;
      held_in      = held_ff;
      lamp_in      = lamp_ff;
      setting_in   = setting_ff | enter_ff;
      off_armed_in = off_armed_ff | arm_ff;
      rate_in      = rate_ff;
      init_in      = init_ff;
      blink_in     = NO_LEVEL;
      lv_bar       = bar_of(adc_ff, thr_ff[0], thr_ff[1], thr_ff[2], thr_ff[3]);
      lv           = NO_LEVEL;
      leave_any    = 1'b0;
      case (kind_ff)
         KIND_REFRESH: begin
            if (mode_ff inside {MODE_BAT, MODE_BAT_INSTR}) begin
               // discharging: level may only fall, on a tick
               lv = lv_bar;
               if (held_ff != NO_LEVEL && (lv_bar > held_ff || !tick_ff)) begin
                  lv = held_ff;
               end
               held_in = lv;
               lamp_in = {lv >= 3'd5, lv >= 3'd4, lv >= 3'd3, lv >= 3'd2, 1'b1};
            end else if (mode_ff inside {MODE_RATE_SET, MODE_RATE_INSTR}) begin
               // rate shown on one lamp, added to the lamps already lit
               case (rate_ff)
                  3'd1:    lamp_in = lamp_ff | 5'b00001;
                  3'd2:    lamp_in = lamp_ff | 5'b00010;
                  3'd3:    lamp_in = lamp_ff | 5'b00100;
                  default: lamp_in = lamp_ff;
               endcase
            end else if (mode_ff == MODE_CHARGING) begin
               // charging: level may only rise, on a tick
               lv = nearly_full_ff ? FULL_BAR : lv_bar;
               if (held_ff != NO_LEVEL && (lv < held_ff || !tick_ff)) begin
                  lv = held_ff;
               end
               held_in = lv;
               lamp_in = lamp_ff |
                         {lv >= 3'd6, lv >= 3'd5, lv >= 3'd4, lv >= 3'd3, 1'b1};
            end
            // exit ticks
            if (set_exit_ff) begin
               setting_in = 1'b0;
            end
            if (set_exit_ff || instr_exit_ff) begin
               leave_any = 1'b1;
            end
            if (leave_any) begin
               if (off_armed_in) begin
                  off_armed_in = 1'b0;
                  mode_in      = MODE_OFF;
               end else begin
                  mode_in = MODE_BAT;
               end
            end
            // a second exit in the same item sees the armed flag already spent
            if (set_exit_ff && instr_exit_ff && mode_in == MODE_OFF) begin
               mode_in = MODE_BAT;
            end
            if (mode_in == MODE_OFF) begin
               lamp_in = '0;
            end
         end
         KIND_SET_VALUE: begin
            if (setting_in) begin
               if (target_ff == MODE_GEAR_SET) begin
                  init_in = value_ff;
               end else begin
                  rate_in = value_ff;
               end
               mode_in  = target_ff;
               lamp_in  = '0;
               blink_in = value_ff;
            end
         end
         KIND_CHG_MODE: begin
            lamp_in = '0;
            mode_in = target_ff;
         end
         KIND_CLR_STAT: begin
            lamp_in    = '0;
            setting_in = 1'b0;
         end
         KIND_INIT: begin
            lamp_in = '0;
            held_in = NO_LEVEL;
         end
         default: begin
            setting_in   = setting_ff | enter_ff;
         end
      endcase
   end

   // handshake registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff        <= req_kind;
         adc_ff         <= req_battery_level[CMP_W-1:0];
         nearly_full_ff <= req_charge_nearly_full;
         tick_ff        <= req_gear_update_due;
         set_exit_ff    <= req_setting_exit_due;
         instr_exit_ff  <= req_instruction_exit_due;
         arm_ff         <= req_arm_off;
         enter_ff       <= req_enter_setting;
         target_ff      <= req_target_mode;
         value_ff       <= req_setting_value;
      end
   end

   // block state, updated once per processed transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         held_ff      <= NO_LEVEL;
         lamp_ff      <= '0;
         setting_ff   <= 1'b0;
         off_armed_ff <= 1'b0;
         rate_ff      <= NO_LEVEL;
         init_ff      <= NO_LEVEL;
      end else if (go) begin
         mode_ff      <= mode_in;
         held_ff      <= held_in;
         lamp_ff      <= lamp_in;
         setting_ff   <= setting_in;
         off_armed_ff <= off_armed_in;
         rate_ff      <= rate_in;
         init_ff      <= init_in;
      end
   end

   // blink count of the response
   always_ff @(posedge clock) begin
      if (go) begin
         blink_ff <= blink_in;
      end
   end

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff[0] <= THR_1_RST[CMP_W-1:0];
         thr_ff[1] <= THR_2_RST[CMP_W-1:0];
         thr_ff[2] <= THR_3_RST[CMP_W-1:0];
         thr_ff[3] <= THR_4_RST[CMP_W-1:0];
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THR_1: thr_ff[0] <= csr_wdata[CMP_W-1:0];
            CSR_THR_2: thr_ff[1] <= csr_wdata[CMP_W-1:0];
            CSR_THR_3: thr_ff[2] <= csr_wdata[CMP_W-1:0];
            CSR_THR_4: thr_ff[3] <= csr_wdata[CMP_W-1:0];
            default:   thr_ff[0] <= thr_ff[0];
         endcase
      end
   end

   // response outputs: state after the item plus its blink count
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_led_pattern   = lamp_ff;
   assign rsp_shown_level   = held_ff;
   assign rsp_display_mode  = mode_ff;
   assign rsp_rate_value    = rate_ff;
   assign rsp_initial_level = init_ff;
   assign rsp_blink_request = blink_ff;

   // checks
   `BBLI_ASSERT_SAME(a_held_range, clock, reset, 1'b1, held_ff <= FULL_BAR,
      "held level beyond full bar")
   `BBLI_ASSERT_SAME(a_off_dark, clock, reset, mode_ff == MODE_OFF, lamp_ff == '0,
      "lamps lit in off mode")
   `BBLI_ASSERT_NEXT(a_stall_holds, clock, reset, req_stall, in_valid_ff,
      "input register emptied while stalled")

endmodule

`default_nettype wire
